// File: rtl/bpq_pkg.sv
// Shared types, constants and helper functions of the bucket priority queue.
// No dependencies; the interfaces, engine and top level refer to this package by scope.
package bpq_pkg;

   localparam int CAPACITY   = 64;
   localparam int LEVEL_W    = 4;
   localparam int LEVELS     = 1 << LEVEL_W;
   localparam int ELEM_WIDTH = 32;
   localparam int ENT_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_LEVEL = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   localparam logic REQ_ENQ = 1'b0;
   localparam logic REQ_DEQ = 1'b1;

   // Register index is taken from paddr bit 2 (one register, byte address 0).
   localparam logic CSR_IDX_LAST_LEVEL = 1'b0;
   localparam logic [LEVEL_W-1:0] LAST_LEVEL_RESET = 4'd15;

   typedef struct packed {
      logic                  valid;
      status_type            status;
      logic [ELEM_WIDTH-1:0] removed_elem;
      logic [LEVEL_W-1:0]    removed_level;
      logic [ELEM_WIDTH-1:0] head_elem;
      logic [LEVEL_W-1:0]    head_level;
      logic                  queue_empty;
      logic [CNT_W-1:0]      held_count;
   } result_type;

   typedef struct packed {
      logic                  we;
      logic [ENT_W-1:0]      waddr;
      logic [ELEM_WIDTH-1:0] wdata;
      logic                  re;
      logic [ENT_W-1:0]      raddr;
   } value_port_type;

   typedef struct packed {
      logic             we;
      logic [ENT_W-1:0] waddr;
      logic [ENT_W-1:0] wdata;
      logic             re;
      logic [ENT_W-1:0] raddr;
   } link_port_type;

   typedef struct packed {
      logic               any;
      logic [LEVEL_W-1:0] level;
   } first_type;

   // Most urgent non-empty level; any is low when every level is empty.
   function automatic first_type first_level(input logic [LEVELS-1:0] nonempty);
      first_type f;
      f.any   = |nonempty;
      f.level = '0;
      for (int l = LEVELS - 1; l >= 0; l--) begin
         if (nonempty[l]) begin
            f.level = LEVEL_W'(l);
         end
      end
      return f;
   endfunction

endpackage

// File: rtl/bpq_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on bpq_pkg for field widths.
interface bpq_req_if;
   logic                           valid;
   logic                           ready;
   logic                           req_type;
   logic [bpq_pkg::ELEM_WIDTH-1:0] elem_in;
   logic [bpq_pkg::LEVEL_W-1:0]    level_in;

   modport source(output valid, req_type, elem_in, level_in, input ready);
   modport sink(input valid, req_type, elem_in, level_in, output ready);
endinterface

interface bpq_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     status;
   logic [bpq_pkg::ELEM_WIDTH-1:0] removed_elem;
   logic [bpq_pkg::LEVEL_W-1:0]    removed_level;
   logic [bpq_pkg::ELEM_WIDTH-1:0] head_elem;
   logic [bpq_pkg::LEVEL_W-1:0]    head_level;
   logic                           queue_empty;
   logic [bpq_pkg::CNT_W-1:0]      held_count;

   modport source(output valid, status, removed_elem, removed_level, head_elem,
                  head_level, queue_empty, held_count, input ready);
   modport sink(input valid, status, removed_elem, removed_level, head_elem,
                head_level, queue_empty, held_count, output ready);
endinterface

// File: rtl/bpq_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module bpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/bpq_engine.sv
// Request sequencer of the bucket priority queue: level heads and tails, free list,
// element count, and the read-modify-write traffic to the value and link memories.
// Depends on bpq_pkg and bpq_if; the memories themselves sit in the top level.
module bpq_engine (
   input  logic                           clock,
   input  logic                           reset,
   bpq_req_if.sink                        req_chan,
   input  logic [bpq_pkg::LEVEL_W-1:0]    last_level,
   input  logic                           out_free,
   output bpq_pkg::value_port_type        vport,
   input  logic [bpq_pkg::ELEM_WIDTH-1:0] value_rdata,
   output bpq_pkg::link_port_type         lport,
   input  logic [bpq_pkg::ENT_W-1:0]      link_rdata,
   output bpq_pkg::result_type            result
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_FIN  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [bpq_pkg::ENT_W-1:0]     head_ff [bpq_pkg::LEVELS];
   logic [bpq_pkg::ENT_W-1:0]     head_in [bpq_pkg::LEVELS];
   logic [bpq_pkg::ENT_W-1:0]     tail_ff [bpq_pkg::LEVELS];
   logic [bpq_pkg::ENT_W-1:0]     tail_in [bpq_pkg::LEVELS];
   logic [bpq_pkg::LEVELS-1:0]    nonempty_ff, nonempty_in;
   logic [bpq_pkg::ENT_W-1:0]     free_head_ff, free_head_in;
   logic [bpq_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [bpq_pkg::CAPACITY-1:0]  link_valid_ff, link_valid_in;

   // Request captured at acceptance.
   logic                          op_ff;
   bpq_pkg::status_type           status_ff;
   logic [bpq_pkg::LEVEL_W-1:0]   lvl_ff;
   logic [bpq_pkg::ENT_W-1:0]     ent_ff;
   logic                          lvalid_ff;

   // Response fields waiting for the head value read.
   bpq_pkg::status_type           p_status_ff;
   logic [bpq_pkg::ELEM_WIDTH-1:0] p_rem_elem_ff, p_rem_elem_in;
   logic [bpq_pkg::LEVEL_W-1:0]   p_rem_level_ff, p_rem_level_in;
   logic [bpq_pkg::LEVEL_W-1:0]   p_head_level_ff;
   logic                          p_head_any_ff;
   logic [bpq_pkg::CNT_W-1:0]     p_count_ff;

   logic                          accept;
   logic                          is_enq;
   bpq_pkg::first_type            fl_now, fl_new;
   bpq_pkg::status_type           acc_status;
   logic [bpq_pkg::ENT_W-1:0]     acc_ent;
   logic [bpq_pkg::LEVEL_W-1:0]   acc_lvl;
   logic [bpq_pkg::ENT_W-1:0]     next_link;
   logic                          exec_ok;

   assign req_chan.ready = (state_ff == S_IDLE) || ((state_ff == S_FIN) && out_free);
   assign accept         = req_chan.valid && req_chan.ready;
   assign is_enq         = (req_chan.req_type == bpq_pkg::REQ_ENQ);
   assign fl_now         = bpq_pkg::first_level(nonempty_ff);

   always_comb begin
      if (is_enq) begin
         if (req_chan.level_in > last_level) begin
            acc_status = bpq_pkg::ST_BAD_LEVEL;
         end else if (count_ff == bpq_pkg::CNT_W'(bpq_pkg::CAPACITY)) begin
            acc_status = bpq_pkg::ST_FULL;
         end else begin
            acc_status = bpq_pkg::ST_OK;
         end
         acc_ent = free_head_ff;
         acc_lvl = req_chan.level_in;
      end else begin
         acc_status = fl_now.any ? bpq_pkg::ST_OK : bpq_pkg::ST_EMPTY;
         acc_ent    = head_ff[fl_now.level];
         acc_lvl    = fl_now.level;
      end
   end

   // Link entries never written are taken to hold their free-list chain value.
   assign next_link = lvalid_ff ? link_rdata :
                      ((ent_ff == bpq_pkg::ENT_W'(bpq_pkg::CAPACITY - 1)) ? '0 :
                       ent_ff + 1'b1);
   assign exec_ok   = (state_ff == S_EXEC) && (status_ff == bpq_pkg::ST_OK);

   // Link reads only at acceptance and link writes only in the update cycle, so the
   // two never meet on one entry in the same cycle. The value memory is read for a
   // dequeue at acceptance and for the new head in the update cycle.
   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      nonempty_in    = nonempty_ff;
      free_head_in   = free_head_ff;
      count_in       = count_ff;
      link_valid_in  = link_valid_ff;
      p_rem_elem_in  = '0;
      p_rem_level_in = '0;
      lport.re       = accept;
      lport.raddr    = acc_ent;
      lport.we       = 1'b0;
      lport.waddr    = ent_ff;
      lport.wdata    = free_head_ff;
      if (exec_ok) begin
         if (op_ff == bpq_pkg::REQ_ENQ) begin
            free_head_in = next_link;
            if (nonempty_ff[lvl_ff]) begin
               lport.we    = 1'b1;
               lport.waddr = tail_ff[lvl_ff];
               lport.wdata = ent_ff;
            end else begin
               head_in[lvl_ff]     = ent_ff;
               nonempty_in[lvl_ff] = 1'b1;
            end
            tail_in[lvl_ff] = ent_ff;
            count_in        = count_ff + 1'b1;
         end else begin
            if (head_ff[lvl_ff] == tail_ff[lvl_ff]) begin
               nonempty_in[lvl_ff] = 1'b0;
            end else begin
               head_in[lvl_ff] = next_link;
            end
            lport.we       = 1'b1;
            lport.waddr    = ent_ff;
            lport.wdata    = free_head_ff;
            free_head_in   = ent_ff;
            count_in       = count_ff - 1'b1;
            p_rem_elem_in  = value_rdata;
            p_rem_level_in = lvl_ff;
         end
      end
      if (lport.we) begin
         link_valid_in[lport.waddr] = 1'b1;
      end
   end

   assign fl_new = bpq_pkg::first_level(nonempty_in);

   always_comb begin
      vport.we    = accept && is_enq && (acc_status == bpq_pkg::ST_OK);
      vport.waddr = free_head_ff;
      vport.wdata = req_chan.elem_in;
      if (state_ff == S_EXEC) begin
         vport.re    = fl_new.any;
         vport.raddr = head_in[fl_new.level];
      end else begin
         vport.re    = accept && !is_enq && (acc_status == bpq_pkg::ST_OK);
         vport.raddr = acc_ent;
      end
   end

   always_comb begin
      unique case (state_ff)
         S_IDLE: begin
            state_in = accept ? S_EXEC : S_IDLE;
         end
         S_EXEC: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!out_free) begin
               state_in = S_FIN;
            end else begin
               state_in = accept ? S_EXEC : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         nonempty_ff   <= '0;
         free_head_ff  <= '0;
         count_ff      <= '0;
         link_valid_ff <= '0;
      end else begin
         state_ff      <= state_in;
         nonempty_ff   <= nonempty_in;
         free_head_ff  <= free_head_in;
         count_ff      <= count_in;
         link_valid_ff <= link_valid_in;
      end
   end

   // Heads and tails are only used for levels marked non-empty.
   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
      if (accept) begin
         op_ff     <= req_chan.req_type;
         status_ff <= acc_status;
         lvl_ff    <= acc_lvl;
         ent_ff    <= acc_ent;
         lvalid_ff <= link_valid_ff[acc_ent];
      end
      if (state_ff == S_EXEC) begin
         p_status_ff     <= status_ff;
         p_rem_elem_ff   <= p_rem_elem_in;
         p_rem_level_ff  <= p_rem_level_in;
         p_head_level_ff <= fl_new.any ? fl_new.level : '0;
         p_head_any_ff   <= fl_new.any;
         p_count_ff      <= count_in;
      end
   end

   always_comb begin
      result.valid         = (state_ff == S_FIN) && out_free;
      result.status        = p_status_ff;
      result.removed_elem  = p_rem_elem_ff;
      result.removed_level = p_rem_level_ff;
      result.head_elem     = p_head_any_ff ? value_rdata : '0;
      result.head_level    = p_head_level_ff;
      result.queue_empty   = !p_head_any_ff;
      result.held_count    = p_count_ff;
   end

endmodule

// File: rtl/bucket_priority_queue_core.sv
// Top level of the bucket priority queue: configuration register, value and link
// memories, request sequencer and response register. Depends on bpq_pkg, bpq_if,
// bpq_ram and bpq_engine.
//
//   channel    direction  handshake               payload
//   req_chan   in         valid/ready             req_type, elem_in, level_in
//   rsp_chan   out        valid/ready             status, removed/head fields, count
//   csr        in         psel/penable/pwrite     paddr, pwdata, prdata (pready high)
//
// Each word passes S_EXEC and S_FIN, and the next word is taken no earlier than S_FIN:
// the link memory read of the accepted word returns in S_EXEC, where the
// head, tail and free list are updated and the new head value is read; that value
// is loaded into the response register in S_FIN while the next word is
// taken. Reset is synchronous and needs no clearing pass. A stalled response holds
// the next word in its last cycle until the response register frees.
module bucket_priority_queue_core (
   input  logic                           clock,
   input  logic                           reset,
   bpq_req_if.sink                        req_chan,
   bpq_rsp_if.source                      rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [bpq_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bpq_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [bpq_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   logic [bpq_pkg::LEVEL_W-1:0]    last_level_ff;
   logic                           csr_write;
   logic                           out_free;
   logic                           rsp_valid_ff;
   bpq_pkg::result_type            rsp_ff;
   bpq_pkg::result_type            result;
   bpq_pkg::value_port_type        vport;
   bpq_pkg::link_port_type         lport;
   logic [bpq_pkg::ELEM_WIDTH-1:0] value_rdata;
   logic [bpq_pkg::ENT_W-1:0]      link_rdata;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == bpq_pkg::CSR_IDX_LAST_LEVEL) ?
                      bpq_pkg::CSR_DATA_W'(last_level_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff <= bpq_pkg::LAST_LEVEL_RESET;
      end else if (csr_write && (paddr[2] == bpq_pkg::CSR_IDX_LAST_LEVEL)) begin
         last_level_ff <= pwdata[bpq_pkg::LEVEL_W-1:0];
      end
   end

   bpq_ram #(
      .WIDTH(bpq_pkg::ELEM_WIDTH),
      .DEPTH(bpq_pkg::CAPACITY)
   ) u_value_ram (
      .clock(clock),
      .we   (vport.we),
      .waddr(vport.waddr),
      .wdata(vport.wdata),
      .re   (vport.re),
      .raddr(vport.raddr),
      .rdata(value_rdata)
   );

   bpq_ram #(
      .WIDTH(bpq_pkg::ENT_W),
      .DEPTH(bpq_pkg::CAPACITY)
   ) u_link_ram (
      .clock(clock),
      .we   (lport.we),
      .waddr(lport.waddr),
      .wdata(lport.wdata),
      .re   (lport.re),
      .raddr(lport.raddr),
      .rdata(link_rdata)
   );

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   bpq_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .last_level (last_level_ff),
      .out_free   (out_free),
      .vport      (vport),
      .value_rdata(value_rdata),
      .lport      (lport),
      .link_rdata (link_rdata),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_ff <= result;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_ff.status;
   assign rsp_chan.removed_elem  = rsp_ff.removed_elem;
   assign rsp_chan.removed_level = rsp_ff.removed_level;
   assign rsp_chan.head_elem     = rsp_ff.head_elem;
   assign rsp_chan.head_level    = rsp_ff.head_level;
   assign rsp_chan.queue_empty   = rsp_ff.queue_empty;
   assign rsp_chan.held_count    = rsp_ff.held_count;

`ifndef ASSERT_OFF
   // The emptiness flag and the element count describe the same queue.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.queue_empty == (rsp_chan.held_count == '0)))
      else $error("queue_empty disagrees with held_count");

   // A word is never followed by another in the very next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken during the update cycle");

   // The count never passes the store size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.held_count <= bpq_pkg::CNT_W'(bpq_pkg::CAPACITY)))
      else $error("held_count above capacity");
`endif

endmodule
